[rtl/core/lrd_pkg.sv]
// ----------------------------------------------------------------------------
// lrd_pkg : shared definitions for the LZSS ring decoder
// Ring geometry, sequencer and parse enums, and the packer control structs.
// ----------------------------------------------------------------------------
package lrd_pkg;

	// Ring geometry
	localparam int RING_BITS   = 12;
	localparam int RING_SIZE   = 1 << RING_BITS;
	localparam int RING_START  = 4078;
	localparam int CLEAR_LIMIT = 4077;
	// stream-start clear saturates at the ring size
	localparam int CLR_LIM     = (CLEAR_LIMIT > RING_SIZE) ? RING_SIZE : CLEAR_LIMIT;

	// Token format
	localparam logic [15:0] CTRL_FILL = 16'hff00;
	localparam logic [4:0]  MIN_MATCH = 5'd3;

	typedef logic [RING_BITS-1:0] ring_addr_t;
	typedef logic [RING_BITS:0]   clr_cnt_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_INIT,
		S_WAIT,
		S_CLEAR,
		S_EXEC,
		S_COPY_RD,
		S_COPY_WR
	} seq_state_t;

	// Stream parse phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_NEXT,
		PH_DATA,
		PH_REFHI
	} phase_t;

	// Sequencer to packer
	typedef struct packed {
		logic        put;
		logic [7:0]  data;
		logic        last;
		logic        restart;
		logic        load;
		logic [30:0] count;
	} pk_ctl_t;

	// Packer to sequencer
	typedef struct packed {
		logic held;
		logic slot_free;
		logic finish;
	} pk_sts_t;

endpackage

[rtl/core/lzss_ring_decoder_words.sv]
// ----------------------------------------------------------------------------
// lzss_ring_decoder_words : LZSS decoder, 4K history ring, 16-bit words out
// Parses header, flag bytes, literals and references under a small
// sequencer; reference copies step through the ring one byte at a time.
// ----------------------------------------------------------------------------
//  channel   ports                                   moves
//  code      code_valid/code_ready, data_byte,       one compressed byte
//            stream_start
//  word      word_valid/word_ready, out_word,        one decoded word
//            word_index, last_of_run, stream_done
//
//  Header, flag and plain bytes are accepted, then executed; a reference
//  is accepted and executed likewise, then each copied byte takes a ring
//  read, then a ring write, one byte at a time.
//  After reset all RING_SIZE (4096) ring entries are zeroed before the
//  first byte is taken; a stream start zeroes CLR_LIM (4077) entries first.
//  A full word register with word_ready low holds a put that completes a word.
// ----------------------------------------------------------------------------
module lzss_ring_decoder_words (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        code_valid,
	output logic        code_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_start,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [15:0] out_word,
	output logic [30:0] word_index,
	output logic        last_of_run,
	output logic        stream_done
);

	lrd_pkg::seq_state_t state_q, state_d;
	lrd_pkg::phase_t     ph_q;
	logic [7:0]          byte_q;
	logic [15:0]         ctrl_q;
	logic [31:0]         hdr_q;
	logic [1:0]          seen_q;
	logic [7:0]          reflo_q;
	lrd_pkg::ring_addr_t src_q;
	logic [4:0]          rem_q;
	lrd_pkg::ring_addr_t wp_q;
	lrd_pkg::clr_cnt_t   clr_q;

	lrd_pkg::pk_ctl_t    pk_ctl;
	lrd_pkg::pk_sts_t    pk_sts;

	logic                ring_we;
	lrd_pkg::ring_addr_t ring_waddr;
	logic [7:0]          ring_wdata;
	logic                ring_re;
	logic [7:0]          ring_rdata;

	logic                accept;
	logic [15:0]         ctrl_sh;
	logic [15:0]         ctrl_eff;
	logic                flag_load;
	logic                exec_put;
	logic                copy_put;
	logic                put_req;
	logic [7:0]          put_data;
	logic                stall;
	logic                put_go;
	logic                finish_go;
	logic                clr_end;
	logic                clr_we;
	logic [31:0]         hdr_new;
	logic [15:0]         off_w;

	// shared decode terms
	assign accept    = code_valid && code_ready;
	assign ctrl_sh   = ctrl_q >> 1;
	assign flag_load = (ph_q == lrd_pkg::PH_NEXT) && !ctrl_sh[8];
	assign ctrl_eff  = (ph_q == lrd_pkg::PH_NEXT) ? ctrl_sh : ctrl_q;
	assign exec_put  = (state_q == lrd_pkg::S_EXEC) && !ctrl_eff[0]
		&& ((ph_q == lrd_pkg::PH_DATA)
		|| ((ph_q == lrd_pkg::PH_NEXT) && ctrl_sh[8]));
	assign copy_put  = (state_q == lrd_pkg::S_COPY_WR);
	assign put_req   = exec_put || copy_put;
	assign put_data  = copy_put ? ring_rdata : byte_q;
	assign stall     = put_req && pk_sts.held && !pk_sts.slot_free;
	assign put_go    = put_req && !stall;
	assign finish_go = put_go && pk_sts.finish;
	assign hdr_new   = {hdr_q[23:0], byte_q};
	assign off_w     = {4'd0, byte_q[7:4], reflo_q};

	// ring clear sweep end
	always_comb begin
		if (state_q == lrd_pkg::S_INIT) begin
			clr_end = (clr_q == lrd_pkg::clr_cnt_t'(lrd_pkg::RING_SIZE));
		end else begin
			clr_end = (clr_q == lrd_pkg::clr_cnt_t'(lrd_pkg::CLR_LIM));
		end
	end
	assign clr_we = ((state_q == lrd_pkg::S_INIT) || (state_q == lrd_pkg::S_CLEAR))
		&& !clr_end;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrd_pkg::S_INIT: begin
				if (clr_end) begin
					state_d = lrd_pkg::S_WAIT;
				end
			end
			lrd_pkg::S_WAIT: begin
				if (code_valid) begin
					if (stream_start) begin
						state_d = lrd_pkg::S_CLEAR;
					end else if (ph_q != lrd_pkg::PH_IDLE) begin
						state_d = lrd_pkg::S_EXEC;
					end
				end
			end
			lrd_pkg::S_CLEAR: begin
				if (clr_end) begin
					state_d = lrd_pkg::S_EXEC;
				end
			end
			lrd_pkg::S_EXEC: begin
				if (ph_q == lrd_pkg::PH_REFHI) begin
					state_d = lrd_pkg::S_COPY_RD;
				end else if (!stall) begin
					state_d = lrd_pkg::S_WAIT;
				end
			end
			lrd_pkg::S_COPY_RD: begin
				state_d = lrd_pkg::S_COPY_WR;
			end
			lrd_pkg::S_COPY_WR: begin
				if (!stall) begin
					if (finish_go || (rem_q == 5'd1)) begin
						state_d = lrd_pkg::S_WAIT;
					end else begin
						state_d = lrd_pkg::S_COPY_RD;
					end
				end
			end
			default: begin
				state_d = lrd_pkg::S_INIT;
			end
		endcase
	end

	// outputs: handshake, ring port, packer control
	always_comb begin
		code_ready    = (state_q == lrd_pkg::S_WAIT);
		ring_we       = clr_we || put_go;
		ring_waddr    = clr_we ? clr_q[lrd_pkg::RING_BITS-1:0] : wp_q;
		ring_wdata    = clr_we ? 8'd0 : put_data;
		ring_re       = (state_q == lrd_pkg::S_COPY_RD);
		pk_ctl.put    = put_go;
		pk_ctl.data   = put_data;
		pk_ctl.last   = exec_put || (rem_q <= 5'd2);
		pk_ctl.restart = (state_q == lrd_pkg::S_WAIT) && code_valid && stream_start;
		pk_ctl.load   = (state_q == lrd_pkg::S_EXEC) && (ph_q == lrd_pkg::PH_HEADER)
			&& (seen_q == 2'd3);
		pk_ctl.count  = hdr_new[31:1];
	end

	// sequencer and parse registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrd_pkg::S_INIT;
			ph_q    <= lrd_pkg::PH_IDLE;
			ctrl_q  <= '0;
			hdr_q   <= '0;
			seen_q  <= '0;
			rem_q   <= '0;
			wp_q    <= lrd_pkg::ring_addr_t'(lrd_pkg::RING_START);
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_q <= clr_q + lrd_pkg::clr_cnt_t'(1);
			end
			if (put_go) begin
				wp_q <= wp_q + lrd_pkg::ring_addr_t'(1);
			end
			// new stream opens
			if (accept && stream_start) begin
				wp_q   <= lrd_pkg::ring_addr_t'(lrd_pkg::RING_START);
				ctrl_q <= '0;
				hdr_q  <= '0;
				seen_q <= '0;
				ph_q   <= lrd_pkg::PH_HEADER;
				clr_q  <= '0;
			end
			// one parse step
			if (state_q == lrd_pkg::S_EXEC) begin
				case (ph_q)
					lrd_pkg::PH_HEADER: begin
						hdr_q  <= hdr_new;
						seen_q <= seen_q + 2'd1;
						if (seen_q == 2'd3) begin
							ph_q <= (hdr_new[31:1] == 31'd0) ? lrd_pkg::PH_IDLE
								: lrd_pkg::PH_NEXT;
						end
					end
					lrd_pkg::PH_NEXT, lrd_pkg::PH_DATA: begin
						if (flag_load) begin
							ctrl_q <= lrd_pkg::CTRL_FILL | {8'd0, byte_q};
							ph_q   <= lrd_pkg::PH_DATA;
						end else if (!stall) begin
							ctrl_q <= ctrl_eff;
							if (!ctrl_eff[0]) begin
								ph_q <= finish_go ? lrd_pkg::PH_IDLE : lrd_pkg::PH_NEXT;
							end else begin
								ph_q <= lrd_pkg::PH_REFHI;
							end
						end
					end
					lrd_pkg::PH_REFHI: begin
						rem_q <= {1'b0, byte_q[3:0]} + lrd_pkg::MIN_MATCH;
						ph_q  <= lrd_pkg::PH_NEXT;
					end
					default: begin
						ph_q <= ph_q;
					end
				endcase
			end
			// copy progress
			if (copy_put && put_go) begin
				rem_q <= rem_q - 5'd1;
				if (finish_go) begin
					ph_q <= lrd_pkg::PH_IDLE;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
		end
		if ((state_q == lrd_pkg::S_EXEC) && !flag_load && !stall
			&& ctrl_eff[0]
			&& ((ph_q == lrd_pkg::PH_DATA) || (ph_q == lrd_pkg::PH_NEXT))) begin
			reflo_q <= byte_q;
		end
		if ((state_q == lrd_pkg::S_EXEC) && (ph_q == lrd_pkg::PH_REFHI)) begin
			src_q <= lrd_pkg::ring_addr_t'(off_w);
		end else if (copy_put && put_go) begin
			src_q <= src_q + lrd_pkg::ring_addr_t'(1);
		end
	end

	lrd_ring u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (src_q),
		.rdata (ring_rdata)
	);

	lrd_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (pk_ctl),
		.sts         (pk_sts),
		.word_ready  (word_ready),
		.word_valid  (word_valid),
		.out_word    (out_word),
		.word_index  (word_index),
		.last_of_run (last_of_run),
		.stream_done (stream_done)
	);

`ifndef ASSERT_OFF
	// a completed word is only pushed into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		pk_ctl.put && pk_sts.held |-> pk_sts.slot_free)
		else $error("word pushed into a busy output register");

	// a copy read always has bytes left to copy, at most eighteen
	a_copy_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lrd_pkg::S_COPY_RD) |-> (rem_q != 5'd0) && (rem_q <= 5'd18))
		else $error("copy length out of range");

	// a stream start item always goes through the clear sweep
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream_start |=> (state_q == lrd_pkg::S_CLEAR) && (clr_q == '0))
		else $error("stream start did not begin ring clear");

	// the word that ends the stream also ends its run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && stream_done |-> last_of_run)
		else $error("stream end word not marked last");
`endif

endmodule

[rtl/core/lrd_ring.sv]
// ----------------------------------------------------------------------------
// lrd_ring : history ring storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lrd_ring (
	input  logic               clk,
	input  logic               we,
	input  lrd_pkg::ring_addr_t waddr,
	input  logic [7:0]         wdata,
	input  logic               re,
	input  lrd_pkg::ring_addr_t raddr,
	output logic [7:0]         rdata
);

	logic [7:0] mem [lrd_pkg::RING_SIZE];
	logic [7:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/lrd_packer.sv]
// ----------------------------------------------------------------------------
// lrd_packer : byte pairing and word output register
// Pairs decoded bytes low byte first, counts words down against the header
// count, numbers them and holds one word for the output channel.
// ----------------------------------------------------------------------------
module lrd_packer (
	input  logic             clk,
	input  logic             arst_n,
	input  lrd_pkg::pk_ctl_t ctl,
	output lrd_pkg::pk_sts_t sts,
	input  logic             word_ready,
	output logic             word_valid,
	output logic [15:0]      out_word,
	output logic [30:0]      word_index,
	output logic             last_of_run,
	output logic             stream_done
);

	logic [7:0]  held_q;
	logic        held_valid_q;
	logic [30:0] words_left_q;
	logic [30:0] idx_q;
	logic        ov_q;
	logic [15:0] ow_q;
	logic [30:0] oi_q;
	logic        ol_q;
	logic        od_q;
	logic        finish;

	// this put completes the last word of the stream
	assign finish = held_valid_q && (words_left_q == 31'd1);

	assign sts.held      = held_valid_q;
	assign sts.slot_free = !ov_q || word_ready;
	assign sts.finish    = finish;

	// pairing, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_valid_q <= 1'b0;
			words_left_q <= '0;
			idx_q        <= '0;
			ov_q         <= 1'b0;
		end else begin
			// a new word fills the register, else a taken word empties it
			if (ctl.put && held_valid_q) begin
				ov_q <= 1'b1;
			end else if (word_ready) begin
				ov_q <= 1'b0;
			end
			if (ctl.restart) begin
				held_q       <= '0;
				held_valid_q <= 1'b0;
				words_left_q <= '0;
				idx_q        <= '0;
			end
			if (ctl.load) begin
				words_left_q <= ctl.count;
			end
			if (ctl.put) begin
				if (!held_valid_q) begin
					held_q       <= ctl.data;
					held_valid_q <= 1'b1;
				end else begin
					held_valid_q <= 1'b0;
					words_left_q <= words_left_q - 31'd1;
					idx_q        <= idx_q + 31'd1;
				end
			end
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (ctl.put && held_valid_q) begin
			ow_q <= {ctl.data, held_q};
			oi_q <= idx_q;
			ol_q <= ctl.last || finish;
			od_q <= finish;
		end
	end

	assign word_valid  = ov_q;
	assign out_word    = ow_q;
	assign word_index  = oi_q;
	assign last_of_run = ol_q;
	assign stream_done = od_q;

endmodule
